### hdl/vefc_pkg.sv
// package for the voxel element format converter
// holds type codes, register indexes and shared helpers; no dependencies
package vefc_pkg;

   typedef enum logic [3:0] {
      TYPE_U8  = 4'd0,
      TYPE_S8  = 4'd1,
      TYPE_S16 = 4'd2,
      TYPE_U16 = 4'd3,
      TYPE_S32 = 4'd4,
      TYPE_U32 = 4'd5,
      TYPE_F32 = 4'd6,
      TYPE_F64 = 4'd7,
      TYPE_S64 = 4'd8,
      TYPE_U64 = 4'd9
   } elem_type_type;

   localparam logic [1:0] REG_ELEMENT_TYPE = 2'd0;
   localparam logic [1:0] REG_SWAP_BYTES   = 2'd1;
   localparam logic [1:0] REG_DIRECTION    = 2'd2;
   localparam int         CSR_ADDR_W       = 2;

   typedef struct packed {
      logic [3:0] element_type;
      logic       swap_bytes;
      logic       direction;
   } cfg_type;

   // byte width of a type code, 0 for unused codes
   function automatic logic [3:0] byte_width(input logic [3:0] t);
      case (t)
         TYPE_U8, TYPE_S8:             byte_width = 4'd1;
         TYPE_S16, TYPE_U16:           byte_width = 4'd2;
         TYPE_S32, TYPE_U32, TYPE_F32: byte_width = 4'd4;
         TYPE_F64, TYPE_S64, TYPE_U64: byte_width = 4'd8;
         default:                      byte_width = 4'd0;
      endcase
   endfunction

   function automatic logic [63:0] width_mask(input logic [3:0] w);
      case (w)
         4'd1:    width_mask = 64'h0000_0000_0000_00FF;
         4'd2:    width_mask = 64'h0000_0000_0000_FFFF;
         4'd4:    width_mask = 64'h0000_0000_FFFF_FFFF;
         4'd8:    width_mask = {64{1'b1}};
         default: width_mask = 64'd0;
      endcase
   endfunction

   // reverse the low w bytes
   function automatic logic [63:0] reverse_bytes(input logic [63:0] v, input logic [3:0] w);
      case (w)
         4'd1:    reverse_bytes = {56'd0, v[7:0]};
         4'd2:    reverse_bytes = {48'd0, v[7:0], v[15:8]};
         4'd4:    reverse_bytes = {32'd0, v[7:0], v[15:8], v[23:16], v[31:24]};
         4'd8:    reverse_bytes = {v[7:0], v[15:8], v[23:16], v[31:24],
                                   v[39:32], v[47:40], v[55:48], v[63:56]};
         default: reverse_bytes = 64'd0;
      endcase
   endfunction

   // position of the leading one, 0 for zero
   function automatic logic [5:0] msb_index(input logic [63:0] v);
      logic [5:0] p;
      p = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) p = 6'(i);
      end
      msb_index = p;
   endfunction

endpackage

### hdl/vefc_decode.sv
// decode path: stored element to double bits
// depends on vefc_pkg
module vefc_decode (
   input  vefc_pkg::cfg_type cfg,
   input  logic [63:0]       element_bits,
   output logic [63:0]       result_bits
);

   logic [3:0]  w;
   logic [63:0] v;
   logic        neg;
   logic [63:0] mag;
   logic [5:0]  p;
   logic [63:0] norm;
   logic [53:0] q;
   logic        guard, sticky;
   logic [10:0] expo;
   logic [63:0] int_d;
   logic [7:0]  fe;
   logic [22:0] ff;
   logic [4:0]  fp;
   logic [63:0] f32_d;

   always_comb begin
      w = vefc_pkg::byte_width(cfg.element_type);
      v = element_bits & vefc_pkg::width_mask(w);
      if (cfg.swap_bytes) v = vefc_pkg::reverse_bytes(v, w);

      case (cfg.element_type)
         vefc_pkg::TYPE_S8:  neg = v[7];
         vefc_pkg::TYPE_S16: neg = v[15];
         vefc_pkg::TYPE_S32: neg = v[31];
         vefc_pkg::TYPE_S64: neg = v[63];
         default:            neg = 1'b0;
      endcase
      mag = neg ? ((~v + 64'd1) & vefc_pkg::width_mask(w)) : v;

      // normalize so the leading one sits at bit 63, then round to 53 bits
      p      = vefc_pkg::msb_index(mag);
      norm   = mag << (6'd63 - p);
      guard  = norm[10];
      sticky = |norm[9:0];
      q      = {1'b0, norm[63:11]};
      if (guard && (sticky || norm[11])) q = q + 54'd1;
      expo = 11'd1023 + {5'd0, p};
      if (q[53]) begin
         expo = expo + 11'd1;
         q    = q >> 1;
      end
      int_d = (mag == 64'd0) ? 64'd0 : {neg, expo, q[51:0]};

      // float32 widening, exact
      fe = v[30:23];
      ff = v[22:0];
      fp = 5'(vefc_pkg::msb_index({41'd0, ff}));
      if (fe == 8'hFF) begin
         f32_d = (ff == 23'd0) ? {v[31], 11'h7FF, 52'd0}
                               : {v[31], 11'h7FF, 1'b1, ff[21:0], 29'd0};
      end else if (fe == 8'd0) begin
         f32_d = (ff == 23'd0) ? {v[31], 63'd0}
                 : {v[31], 11'd874 + {6'd0, fp},
                    ({ff, 29'd0} << (6'd23 - {1'b0, fp}))};
      end else begin
         f32_d = {v[31], {3'd0, fe} + 11'd896, ff, 29'd0};
      end

      case (cfg.element_type)
         vefc_pkg::TYPE_F32: result_bits = f32_d;
         vefc_pkg::TYPE_F64: result_bits = v;
         vefc_pkg::TYPE_U8, vefc_pkg::TYPE_S8, vefc_pkg::TYPE_S16, vefc_pkg::TYPE_U16,
         vefc_pkg::TYPE_S32, vefc_pkg::TYPE_U32, vefc_pkg::TYPE_S64,
         vefc_pkg::TYPE_U64: result_bits = int_d;
         default:            result_bits = 64'd0;
      endcase
   end

endmodule

### hdl/vefc_encode.sv
// encode path: double bits to stored element
// depends on vefc_pkg
module vefc_encode (
   input  vefc_pkg::cfg_type cfg,
   input  logic [63:0]       element_bits,
   output logic [63:0]       result_bits
);

   logic        s;
   logic [10:0] e;
   logic [51:0] f;
   logic [52:0] m;
   logic [11:0] sh;
   logic        big;
   logic [63:0] mag, hi_mag, lo_mag, ir;
   logic [116:0] ext;
   logic [63:0] frac_part;
   logic [63:0] half;
   logic [31:0] f32;
   logic [12:0] x;
   logic [24:0] q24;
   logic [5:0]  ssh;
   logic [53:0] sq;
   logic [53:0] srem, shalf;
   logic [63:0] r;
   logic [3:0]  w;

   always_comb begin
      s   = element_bits[63];
      e   = element_bits[62:52];
      f   = element_bits[51:0];
      m   = {(e != 11'd0), f};
      w   = vefc_pkg::byte_width(cfg.element_type);

      // integer: value = m * 2^(e' - 1075)
      sh  = 12'd1075 - ((e == 11'd0) ? 12'd1 : {1'b0, e});
      big = 1'b0;
      mag = 64'd0;
      ext = 117'd0;
      frac_part = 64'd0;
      half = 64'd0;
      if (e >= 11'd1075) begin
         big = (e > 11'd1086);
         mag = big ? {64{1'b1}} : ({11'd0, m} << (e - 11'd1075));
      end else if (sh <= 12'd53) begin
         ext       = {m, 64'd0} >> sh[5:0];
         mag       = {11'd0, ext[116:64]};
         frac_part = ext[63:0];
         half      = 64'h8000_0000_0000_0000;
         if (frac_part > half || (frac_part == half && mag[0])) mag = mag + 64'd1;
      end
      case (cfg.element_type)
         vefc_pkg::TYPE_U8:  begin hi_mag = 64'd255;        lo_mag = 64'd0; end
         vefc_pkg::TYPE_S8:  begin hi_mag = 64'd127;        lo_mag = 64'd128; end
         vefc_pkg::TYPE_S16: begin hi_mag = 64'd32767;      lo_mag = 64'd32768; end
         vefc_pkg::TYPE_U16: begin hi_mag = 64'd65535;      lo_mag = 64'd0; end
         vefc_pkg::TYPE_S32: begin hi_mag = 64'd2147483647; lo_mag = 64'd2147483648; end
         vefc_pkg::TYPE_U32: begin hi_mag = 64'd4294967295; lo_mag = 64'd0; end
         vefc_pkg::TYPE_S64: begin
            hi_mag = 64'd9223372036854774784;
            lo_mag = 64'h8000_0000_0000_0000;
         end
         vefc_pkg::TYPE_U64: begin hi_mag = 64'd18446744073709549568; lo_mag = 64'd0; end
         default:            begin hi_mag = 64'd0; lo_mag = 64'd0; end
      endcase
      if (e == 11'h7FF) ir = 64'd0;
      else if (s) ir = ~((big || mag > lo_mag) ? lo_mag : mag) + 64'd1;
      else ir = (big || mag > hi_mag) ? hi_mag : mag;

      // float32 narrowing
      x     = {2'd0, e} - 13'd1023;
      q24   = 25'd0;
      ssh   = 6'd0;
      sq    = 54'd0;
      srem  = 54'd0;
      shalf = 54'd0;
      if (e == 11'h7FF) begin
         f32 = (f == 52'd0) ? {s, 8'hFF, 23'd0} : {s, 9'h1FF, f[50:29]} | {1'b0, 9'h1FF, 22'd0};
         f32 = (f == 52'd0) ? f32 : ({s, 31'h7FC0_0000} | {9'd0, f[51:29]});
      end else if (e == 11'd0) begin
         f32 = {s, 31'd0};
      end else if ($signed(x) > 13'sd127) begin
         f32 = {s, 8'hFF, 23'd0};
      end else if ($signed(x) >= -13'sd126) begin
         q24 = {1'b0, m[52:29]};
         if (m[28] && ((|m[27:0]) || m[29])) q24 = q24 + 25'd1;
         if (q24[24]) begin
            q24 = q24 >> 1;
            x   = x + 13'd1;
         end
         f32 = ($signed(x) > 13'sd127) ? {s, 8'hFF, 23'd0}
                                       : {s, 8'(x + 13'd127), q24[22:0]};
      end else if (e < 11'd872) begin
         f32 = {s, 31'd0};
      end else begin
         ssh   = 6'(11'd926 - e);
         sq    = {1'b0, m >> ssh};
         srem  = {1'b0, m} & ((54'd1 << ssh) - 54'd1);
         shalf = 54'd1 << (ssh - 6'd1);
         if (srem > shalf || (srem == shalf && sq[0])) sq = sq + 54'd1;
         f32 = {s, sq[30:0]};
      end

      case (cfg.element_type)
         vefc_pkg::TYPE_F32: r = {32'd0, f32};
         vefc_pkg::TYPE_F64: r = element_bits;
         default:            r = ir & vefc_pkg::width_mask(w);
      endcase
      result_bits = cfg.swap_bytes ? vefc_pkg::reverse_bytes(r, w) : r;
   end

endmodule

### hdl/voxel_element_format_converter.sv
// top level of the voxel element format converter
// depends on vefc_pkg, vefc_decode and vefc_encode
//
// usage
//  - req_ channel: one element (element_bits, last_in) per transaction
//  - rsp_ channel: one result (result_bits, last_out) per request transaction
//  - csr_ channel: register writes, index 0 element_type, 1 swap_bytes,
//    2 direction; write only while no transaction is in flight
//  - path: the accept edge loads the input register; the result register
//    takes the converted result when it is empty or being drained
//  - throughput: one transaction per cycle while rsp_ready holds, set by
//    the single pass of conversion logic between the two registers
//  - stall: a stalled result holds in the result register; the input
//    register keeps accepting while the result register can move on
//  - reset clears both valid flags and the registers to zero
module voxel_element_format_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_element_bits,
   input  logic        req_last_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_bits,
   output logic        rsp_last_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [vefc_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [63:0] csr_data
);

   vefc_pkg::cfg_type cfg_ff;
   logic        in_valid_ff;
   logic [63:0] in_bits_ff;
   logic        in_last_ff;
   logic        out_valid_ff;
   logic [63:0] out_bits_ff;
   logic        out_last_ff;
   logic [63:0] dec_bits, enc_bits, out_bits_in;
   logic        out_move, in_move;

   // result register moves when empty or being drained
   assign out_move  = !out_valid_ff || rsp_ready;
   assign in_move   = !in_valid_ff || out_move;
   assign req_ready = in_move;
   assign csr_ready = 1'b1;

   vefc_decode u_dec (.cfg(cfg_ff), .element_bits(in_bits_ff), .result_bits(dec_bits));
   vefc_encode u_enc (.cfg(cfg_ff), .element_bits(in_bits_ff), .result_bits(enc_bits));

   assign out_bits_in = cfg_ff.direction ? enc_bits : dec_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         in_bits_ff   <= '0;
         in_last_ff   <= 1'b0;
         out_bits_ff  <= '0;
         out_last_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               vefc_pkg::REG_ELEMENT_TYPE: cfg_ff.element_type <= csr_data[3:0];
               vefc_pkg::REG_SWAP_BYTES:   cfg_ff.swap_bytes   <= csr_data[0];
               vefc_pkg::REG_DIRECTION:    cfg_ff.direction    <= csr_data[0];
               default: ;
            endcase
         end
         if (in_move) begin
            in_valid_ff <= req_valid;
            in_bits_ff  <= req_element_bits;
            in_last_ff  <= req_last_in;
         end
         if (out_move) begin
            out_valid_ff <= in_valid_ff;
            out_bits_ff  <= out_bits_in;
            out_last_ff  <= in_last_ff;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_bits = out_bits_ff;
   assign rsp_last_out    = out_last_ff;

endmodule

### hdl/vefc_checker.sv
// port checker for the voxel element format converter
// depends on the top level ports only; bound to the top level
module vefc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_result_bits,
   input logic        rsp_last_out
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_bits) && $stable(rsp_last_out))
      else $error("stalled result changed");

   a_no_idle_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("not ready with empty output");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_ready |-> ##2 rsp_valid)
      else $error("accepted transaction lost");

endmodule

bind voxel_element_format_converter vefc_checker u_vefc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_result_bits(rsp_result_bits), .rsp_last_out(rsp_last_out)
);
